/* hw/rtl/dle_pkg.sv */
// Shared types, status codes and the CRC-16 byte update for the deframer.
`timescale 1ns / 1ps

package dle_pkg;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_CRC   = 2'd1;
   localparam logic [1:0] STATUS_TOO_SHORT = 2'd2;
   localparam logic [1:0] STATUS_ABORTED   = 2'd3;

   localparam logic [1:0] REG_CRC_INIT    = 2'd0;
   localparam logic [1:0] REG_START_CODE  = 2'd1;
   localparam logic [1:0] REG_END_CODE    = 2'd2;
   localparam logic [1:0] REG_ESCAPE_CODE = 2'd3;

   typedef struct packed {
      logic [15:0] crc_init;
      logic [7:0]  start_code;
      logic [7:0]  end_code;
      logic [7:0]  escape_code;
   } cfg_type;

   typedef struct packed {
      logic       is_frame_end;
      logic [7:0] content_byte;
      logic [1:0] frame_status;
   } result_type;

   // CRC-16, MSB first, one byte per call (eight shift steps unrolled).
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* hw/rtl/dle_csr.sv */
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module dle_csr
   import dle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       write_en;
   logic [1:0] reg_index;

   assign reg_index  = csr_paddr[3:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            REG_CRC_INIT:    cfg_in.crc_init    = csr_pwdata[15:0];
            REG_START_CODE:  cfg_in.start_code  = csr_pwdata[7:0];
            REG_END_CODE:    cfg_in.end_code    = csr_pwdata[7:0];
            REG_ESCAPE_CODE: cfg_in.escape_code = csr_pwdata[7:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_CRC_INIT:    csr_prdata = {16'h0000, cfg_ff.crc_init};
         REG_START_CODE:  csr_prdata = {24'h000000, cfg_ff.start_code};
         REG_END_CODE:    csr_prdata = {24'h000000, cfg_ff.end_code};
         REG_ESCAPE_CODE: csr_prdata = {24'h000000, cfg_ff.escape_code};
         default:         csr_prdata = 32'h0000_0000;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crc_init    <= 16'h0000;
         cfg_ff.start_code  <= 8'h01;
         cfg_ff.end_code    <= 8'h04;
         cfg_ff.escape_code <= 8'h10;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hw/rtl/dle_deframe.sv */
// Frame state, byte unstuffing, two-word hold-back and CRC check for one word per cycle while step is high.
`timescale 1ns / 1ps

module dle_deframe
   import dle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output logic       res_valid,
   output result_type result
);

   logic        in_frame_ff, in_frame_in;
   logic        escape_pending_ff, escape_pending_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic [7:0]  older_held_ff, older_held_in;
   logic [7:0]  newer_held_ff, newer_held_in;
   logic [1:0]  held_count_ff, held_count_in;
   logic        forwarded_any_ff, forwarded_any_in;

   logic        literal;
   logic [15:0] rx_crc;

   assign rx_crc = {newer_held_ff, older_held_ff};

   always_comb begin
      in_frame_in       = in_frame_ff;
      escape_pending_in = escape_pending_ff;
      running_crc_in    = running_crc_ff;
      older_held_in     = older_held_ff;
      newer_held_in     = newer_held_ff;
      held_count_in     = held_count_ff;
      forwarded_any_in  = forwarded_any_ff;
      literal           = 1'b0;
      res_valid         = 1'b0;
      result            = '0;

      if (step) begin
         if (escape_pending_ff) begin
            escape_pending_in = 1'b0;
            literal           = 1'b1;
         end else if (rx_byte == cfg.escape_code) begin
            escape_pending_in = 1'b1;
         end else if (rx_byte == cfg.start_code) begin
            // A start code inside a frame aborts it; either way a fresh frame begins.
            if (in_frame_ff) begin
               res_valid           = 1'b1;
               result.is_frame_end = 1'b1;
               result.frame_status = STATUS_ABORTED;
            end
            in_frame_in      = 1'b1;
            running_crc_in   = crc_byte(cfg.crc_init, cfg.start_code);
            held_count_in    = 2'd0;
            forwarded_any_in = 1'b0;
         end else if (rx_byte == cfg.end_code) begin
            if (in_frame_ff) begin
               res_valid           = 1'b1;
               result.is_frame_end = 1'b1;
               if (!held_count_ff[1] || !forwarded_any_ff) begin
                  result.frame_status = STATUS_TOO_SHORT;
               end else if (rx_crc == running_crc_ff) begin
                  result.frame_status = STATUS_OK;
               end else begin
                  result.frame_status = STATUS_BAD_CRC;
               end
               in_frame_in      = 1'b0;
               held_count_in    = 2'd0;
               forwarded_any_in = 1'b0;
            end
         end else begin
            literal = 1'b1;
         end

         // The two newest words are held back, since they may be the trailing CRC.
         if (literal && in_frame_ff) begin
            if (held_count_ff[1]) begin
               res_valid           = 1'b1;
               result.content_byte = older_held_ff;
               running_crc_in      = crc_byte(running_crc_ff, older_held_ff);
               forwarded_any_in    = 1'b1;
            end else begin
               held_count_in = held_count_ff + 2'd1;
            end
            older_held_in = newer_held_ff;
            newer_held_in = rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff       <= 1'b0;
         escape_pending_ff <= 1'b0;
         held_count_ff     <= 2'd0;
         forwarded_any_ff  <= 1'b0;
      end else begin
         in_frame_ff       <= in_frame_in;
         escape_pending_ff <= escape_pending_in;
         held_count_ff     <= held_count_in;
         forwarded_any_ff  <= forwarded_any_in;
      end
      running_crc_ff <= running_crc_in;
      older_held_ff  <= older_held_in;
      newer_held_ff  <= newer_held_in;
   end

endmodule

/* hw/rtl/dle_frame_deframer_crc16_core.sv */
// Top level of the byte-stuffed frame deframer with CRC-16 check.
`timescale 1ns / 1ps

// Accepts one received word per cycle when not stalled and returns at most one result word
// for each: a command or payload byte, forwarded two words late so the CRC bytes are never
// passed on, or an end-of-frame status (0 ok, 1 bad CRC, 2 too short, 3 aborted by a new
// start code). Each word passes an input register, then combinational decode and CRC logic,
// then the result register. The rate is one word per clock when the output is not stalled,
// set by the combinational eight-bit CRC update. Configuration is to be written only while
// no word is in flight.
module dle_frame_deframer_crc16_core
   import dle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_frame_end,
   output logic [7:0]  rsp_content_byte,
   output logic [1:0]  rsp_frame_status,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type    cfg;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;
   logic       out_free;
   logic       advance;
   logic       res_valid;
   result_type result;

   dle_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dle_deframe u_deframe (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (advance),
      .rx_byte   (in_byte_ff),
      .res_valid (res_valid),
      .result    (result)
   );

   // The held word is processed only when the result register can take its result.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_byte_ff  <= in_byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_frame_end = rsp_data_ff.is_frame_end;
   assign rsp_content_byte = rsp_data_ff.content_byte;
   assign rsp_frame_status = rsp_data_ff.frame_status;

   // A held input word must not be dropped or overwritten while the output is stalled.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input word lost while stalled");

   // A result produced by the decode stage must show up at the output next cycle.
   assert property (@(posedge clock) disable iff (reset)
      advance && res_valid |=> rsp_valid_ff)
      else $error("decode result not registered");

   // Content words carry no status, and status words carry no content.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.is_frame_end ? rsp_data_ff.content_byte == 8'h00
                                                 : rsp_data_ff.frame_status == STATUS_OK))
      else $error("result word mixes content and status");

endmodule

/* tb/sv/dle_frame_deframer_crc16_core_tb.sv */
// Self-checking testbench for the byte-stuffed frame deframer with CRC-16 check.
`timescale 1ns / 1ps

module dle_frame_deframer_crc16_core_tb
   import dle_pkg::*;
();

   localparam int RUN_LIMIT_NS   = 400000;
   localparam int DRAIN_LIMIT    = 5000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_OFF_LEN   = 100;

   typedef enum logic [1:0] {ROW_PREDICT, ROW_NO_RESULT, ROW_STATUS} row_kind_type;
   typedef enum logic [1:0] {
      SINK_ALWAYS, SINK_COIN, SINK_EVERY_FOURTH, SINK_MOSTLY
   } sink_mode_type;

   typedef struct {
      logic [7:0]   rx;
      row_kind_type kind;
      logic [1:0]   status;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_is_frame_end;
   logic [7:0]  rsp_content_byte;
   logic [1:0]  rsp_frame_status;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'h0;
   logic [31:0] csr_pwdata = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   dle_frame_deframer_crc16_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_is_frame_end (rsp_is_frame_end),
      .rsp_content_byte (rsp_content_byte),
      .rsp_frame_status (rsp_frame_status),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #1 clock = ~clock;

   // Mirror of the deframer state and its registers.
   cfg_type    cfg_now = {16'h0000, 8'h01, 8'h04, 8'h10};
   logic       fr_open;
   logic       fr_escaped;
   logic [15:0] fr_crc;
   logic [7:0] fr_older;
   logic [7:0] fr_newer;
   logic [1:0] fr_held;
   logic       fr_forwarded;

   result_type   frame_results_due[$];
   stim_row_type plan[$];
   int           mismatches = 0;
   bit           gaps_on = 1'b1;
   int           burst_left = 0;
   bit           hold_off_req = 1'b0;

   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
      logic fb;
      for (int k = 7; k >= 0; k--) begin
         fb = crc[15] ^ data[k];
         crc = {crc[14:0], 1'b0};
         if (fb) begin
            crc = crc ^ CRC_POLY;
         end
      end
      return crc;
   endfunction

   function automatic void clear_frame(input logic enter);
      fr_open = enter;
      fr_escaped = 1'b0;
      fr_crc = enter ? crc16_step(cfg_now.crc_init, cfg_now.start_code) : 16'h0000;
      fr_older = 8'h00;
      fr_newer = 8'h00;
      fr_held = 2'd0;
      fr_forwarded = 1'b0;
   endfunction

   // Advances the mirror by one received word; n is 1 when a result word is due.
   task automatic deframe_byte(input logic [7:0] b, output int n, output result_type r);
      logic literal;
      n = 0;
      r = '0;
      literal = 1'b0;
      if (fr_escaped) begin
         fr_escaped = 1'b0;
         literal = 1'b1;
      end else if (b == cfg_now.escape_code) begin
         fr_escaped = 1'b1;
      end else if (b == cfg_now.start_code) begin
         if (fr_open) begin
            n = 1;
            r.is_frame_end = 1'b1;
            r.frame_status = STATUS_ABORTED;
         end
         clear_frame(1'b1);
      end else if (b == cfg_now.end_code) begin
         if (fr_open) begin
            n = 1;
            r.is_frame_end = 1'b1;
            if (fr_held < 2'd2 || !fr_forwarded) begin
               r.frame_status = STATUS_TOO_SHORT;
            end else if ({fr_newer, fr_older} == fr_crc) begin
               r.frame_status = STATUS_OK;
            end else begin
               r.frame_status = STATUS_BAD_CRC;
            end
            clear_frame(1'b0);
         end
      end else begin
         literal = 1'b1;
      end
      if (literal && fr_open) begin
         // Two words stay held so the trailing CRC bytes never leave the block.
         if (fr_held == 2'd2) begin
            n = 1;
            r.content_byte = fr_older;
            fr_crc = crc16_step(fr_crc, fr_older);
            fr_forwarded = 1'b1;
         end else begin
            fr_held = fr_held + 2'd1;
         end
         fr_older = fr_newer;
         fr_newer = b;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s, got 0x%0h, want 0x%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic add_row(input logic [7:0] rx, input row_kind_type kind,
                          input logic [1:0] status = STATUS_OK);
      stim_row_type row;
      row.rx = rx;
      row.kind = kind;
      row.status = status;
      plan = {plan, row};
   endtask

   // Escapes any byte that collides with a code, and now and then one that does not.
   task automatic add_literal(input logic [7:0] b);
      if (b == cfg_now.escape_code || b == cfg_now.start_code || b == cfg_now.end_code ||
          $urandom_range(9) == 0) begin
         add_row(cfg_now.escape_code, ROW_PREDICT);
      end
      add_row(b, ROW_PREDICT);
   endtask

   task automatic add_frame(input logic [7:0] body[$], input bit corrupt,
                            input row_kind_type end_kind);
      logic [15:0] crc;
      crc = crc16_step(cfg_now.crc_init, cfg_now.start_code);
      add_row(cfg_now.start_code, ROW_PREDICT);
      foreach (body[i]) begin
         crc = crc16_step(crc, body[i]);
         add_literal(body[i]);
      end
      if (corrupt) begin
         crc = crc ^ (16'h0001 << $urandom_range(15));
      end
      add_literal(crc[7:0]);
      add_literal(crc[15:8]);
      add_row(cfg_now.end_code, end_kind, STATUS_OK);
   endtask

   task automatic send_word(input stim_row_type row);
      int n;
      result_type r;
      @(negedge clock);
      req_valid <= 1'b1;
      req_rx_byte <= row.rx;
      do @(posedge clock); while (!req_ready);
      deframe_byte(row.rx, n, r);
      case (row.kind)
         ROW_PREDICT: begin
            if (n != 0) begin
               frame_results_due = {frame_results_due, r};
            end
         end
         ROW_STATUS: begin
            r = '0;
            r.is_frame_end = 1'b1;
            r.frame_status = row.status;
            frame_results_due = {frame_results_due, r};
         end
         default: begin
         end
      endcase
   endtask

   task automatic send_plan();
      stim_row_type row;
      while (plan.size() != 0) begin
         row = plan.pop_front();
         send_word(row);
         if (gaps_on) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               repeat ($urandom_range(1, 6)) begin
                  @(negedge clock);
                  req_valid <= 1'b0;
               end
            end else begin
               burst_left--;
            end
         end
      end
   endtask

   task automatic drain_results();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (frame_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      // Words that give no result may still be in the pipeline.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_CRC_INIT:    cfg_now.crc_init = value[15:0];
         REG_START_CODE:  cfg_now.start_code = value[7:0];
         REG_END_CODE:    cfg_now.end_code = value[7:0];
         REG_ESCAPE_CODE: cfg_now.escape_code = value[7:0];
         default: begin
         end
      endcase
   endtask

   task automatic set_config(input cfg_type c);
      write_reg(REG_CRC_INIT, {16'h0000, c.crc_init});
      write_reg(REG_START_CODE, {24'h000000, c.start_code});
      write_reg(REG_END_CODE, {24'h000000, c.end_code});
      write_reg(REG_ESCAPE_CODE, {24'h000000, c.escape_code});
   endtask

   // Result side: a ready pattern picked at random from four modes, plus one long hold-off.
   initial begin : result_sink
      int hold_left;
      int mode_left;
      int tick;
      sink_mode_type sink_mode;
      hold_left = 0;
      mode_left = 0;
      tick = 0;
      sink_mode = SINK_ALWAYS;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left = HOLD_OFF_LEN;
         end
         if (mode_left == 0) begin
            sink_mode = sink_mode_type'($urandom_range(3));
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         tick++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (sink_mode)
               SINK_ALWAYS:       rsp_ready <= 1'b1;
               SINK_COIN:         rsp_ready <= 1'($urandom_range(1));
               SINK_EVERY_FOURTH: rsp_ready <= (tick % 4 == 0);
               default:           rsp_ready <= ($urandom_range(9) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_results_due.size() == 0) begin
            report_mismatch("word with nothing due {end,byte,status}",
                            int'({rsp_is_frame_end, rsp_content_byte, rsp_frame_status}), 0);
         end else begin
            want = frame_results_due.pop_front();
            if (rsp_is_frame_end !== want.is_frame_end) begin
               report_mismatch("is_frame_end", int'(rsp_is_frame_end),
                               int'(want.is_frame_end));
            end
            if (rsp_content_byte !== want.content_byte) begin
               report_mismatch("content_byte", int'(rsp_content_byte),
                               int'(want.content_byte));
            end
            if (rsp_frame_status !== want.frame_status) begin
               report_mismatch("frame_status", int'(rsp_frame_status),
                               int'(want.frame_status));
            end
         end
      end
   end

   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      cfg_type c;
      int done;
      int target;
      int pick;
      int len;
      logic [7:0] body[$];
      clear_frame(1'b0);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words under the reset codes.
      add_row(8'hFF, ROW_NO_RESULT);
      add_row(cfg_now.end_code, ROW_NO_RESULT);
      add_row(cfg_now.escape_code, ROW_NO_RESULT);
      add_row(cfg_now.start_code, ROW_NO_RESULT);   // escaped, so no frame opens
      add_row(cfg_now.start_code, ROW_PREDICT);
      add_row(cfg_now.start_code, ROW_STATUS, STATUS_ABORTED);
      add_row(cfg_now.end_code, ROW_STATUS, STATUS_TOO_SHORT);
      body = '{8'h00, 8'hFF, 8'h10, 8'h01, 8'h04};
      add_frame(body, 1'b0, ROW_STATUS);
      // An escape just before the end code turns it into a held literal.
      add_row(cfg_now.start_code, ROW_PREDICT);
      add_row(8'h5A, ROW_PREDICT);
      add_row(cfg_now.escape_code, ROW_PREDICT);
      add_row(cfg_now.end_code, ROW_PREDICT);
      add_row(8'h00, ROW_PREDICT);
      add_row(cfg_now.end_code, ROW_PREDICT);
      send_plan();

      for (int ph = 1; ph <= 6; ph++) begin
         drain_results();
         c.crc_init = 16'($urandom);
         c.start_code = 8'($urandom);
         case (ph)
            1: c = {16'hFFFF, 8'h00, 8'hFF, 8'h80};
            2: c = {16'h0000, 8'h7F, 8'h00, 8'hFF};
            3: begin
               do c.end_code = 8'($urandom); while (c.end_code == c.start_code);
               do c.escape_code = 8'($urandom);
               while (c.escape_code == c.start_code || c.escape_code == c.end_code);
            end
            4: begin
               // Start and end share a code; start wins, so frames only abort.
               c.end_code = c.start_code;
               c.escape_code = c.start_code ^ 8'h5A;
            end
            5: begin
               // End and escape share a code; escape wins.
               c.escape_code = c.start_code ^ 8'hA5;
               c.end_code = c.escape_code;
            end
            default: begin
               c.end_code = 8'h04;
               c.start_code = 8'h01;
               c.escape_code = 8'h10;
            end
         endcase
         set_config(c);

         gaps_on = (ph != 1);
         if (ph == 1) begin
            hold_off_req = 1'b1;
         end
         target = (ph == 4) ? 60 : 120;
         done = 0;
         while (done < target) begin
            pick = $urandom_range(99);
            len = ($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            body.delete();
            repeat (len) body = {body, 8'($urandom)};
            if (pick < 72) begin
               add_frame(body, 1'b0, ROW_PREDICT);
            end else if (pick < 82) begin
               add_frame(body, 1'b1, ROW_PREDICT);
            end else if (pick < 88) begin
               // Up to two held words and nothing forwarded.
               add_row(cfg_now.start_code, ROW_PREDICT);
               repeat ($urandom_range(2)) add_literal(8'($urandom));
               add_row(cfg_now.end_code, ROW_PREDICT);
            end else if (pick < 94) begin
               // Left open; the next start code aborts it.
               add_row(cfg_now.start_code, ROW_PREDICT);
               foreach (body[i]) add_literal(body[i]);
            end
            if (pick < 94) begin
               done += plan.size();
            end else begin
               repeat ($urandom_range(1, 6)) begin
                  case ($urandom_range(3))
                     0: add_row(cfg_now.start_code, ROW_PREDICT);
                     1: add_row(cfg_now.end_code, ROW_PREDICT);
                     2: add_row(cfg_now.escape_code, ROW_PREDICT);
                     default: add_row(8'($urandom), ROW_PREDICT);
                  endcase
               end
            end
            send_plan();
         end
      end

      drain_results();
      if (frame_results_due.size() != 0) begin
         report_mismatch("results never returned", frame_results_due.size(), 0);
      end
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
